// ----- sv/drae_pkg.sv -----
// Shared types and constants for the DNS reply address extractor.
package drae_pkg;

    // Parser phase, one-hot
    typedef enum logic [7:0] {
        PH_HEADER    = 8'b0000_0001,
        PH_NAME_LEN  = 8'b0000_0010,
        PH_NAME_SKIP = 8'b0000_0100,
        PH_QTAIL     = 8'b0000_1000,
        PH_RR_FIXED  = 8'b0001_0000,
        PH_CAPTURE   = 8'b0010_0000,
        PH_RR_SKIP   = 8'b0100_0000,
        PH_DONE      = 8'b1000_0000
    } phase_t;

    // Result status codes
    typedef enum logic [1:0] {
        ST_FOUND        = 2'd0,
        ST_SERVER_ERROR = 2'd1,
        ST_NO_RECORD    = 2'd2,
        ST_SHORT_HEADER = 2'd3
    } status_t;

    localparam logic [3:0]  HEADER_LAST   = 4'd11;
    localparam logic [3:0]  RR_FIXED_LAST = 4'd9;
    localparam logic [3:0]  RCODE_IDX     = 4'd3;
    localparam logic [3:0]  QDCOUNT_HI    = 4'd4;
    localparam logic [3:0]  QDCOUNT_LO    = 4'd5;
    localparam logic [3:0]  ANCOUNT_HI    = 4'd6;
    localparam logic [3:0]  ANCOUNT_LO    = 4'd7;
    localparam logic [3:0]  TYPE_LO_IDX   = 4'd1;
    localparam logic [3:0]  RDLEN_HI      = 4'd8;
    localparam logic [3:0]  RDLEN_LO      = 4'd9;
    localparam logic [3:0]  ADDR_LAST     = 4'd3;
    localparam logic [7:0]  RCODE_MASK    = 8'h0f;
    localparam logic [7:0]  PTR_MARK      = 8'hc0;
    localparam logic [15:0] QTAIL_LEN     = 16'd4;
    localparam logic [15:0] TYPE_A        = 16'd1;
    localparam logic [15:0] A_RDLEN       = 16'd4;

endpackage

// ----- sv/drae_if.sv -----
// Valid/ready channel interfaces for message bytes and extraction results.
interface drae_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] msg_byte;
    logic       final_byte;

    modport source (output valid, output msg_byte, output final_byte, input ready);
    modport sink   (input valid, input msg_byte, input final_byte, output ready);
endinterface

interface drae_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] address;

    modport source (output valid, output status, output address, input ready);
    modport sink   (input valid, input status, input address, output ready);
endinterface

// ----- sv/dns_reply_address_extractor_core.sv -----
// DNS reply address extractor: byte-wise parser of a DNS reply for the first A record.
//
// Usage:
//   msg    : one byte of the DNS reply per transfer, final_byte marks the last one.
//   result : one transfer per message, carrying status and IPv4 address.
//   Every byte transfer updates the parser state in the same cycle, so one byte
//   is taken per clock unless a pending result stalls it. A final byte loads
//   the result register, offered on the next cycle; non-final bytes give none.
//   Throughput is one byte per cycle, set by the phase/counter update, while
//   the receiver takes results; consecutive messages then follow without a gap.
//   Status: 0 found, 1 server error code, 2 no usable A record, 3 header too
//   short. Address is zero unless status is 0.
//   After the final byte the parser returns to the header phase.
//   Reset (rst_n low, asynchronous) clears the parser to the header phase and
//   empties the result register.
//   If the receiver stalls with a result pending, msg.ready stays low and no
//   byte is taken until the result transfer completes.
module dns_reply_address_extractor_core (
    input  logic                 clk,
    input  logic                 rst_n,
    drae_msg_if.sink             msg,
    drae_result_if.source        result
);
    import drae_pkg::*;

    phase_t      phase_reg,            phase_next;
    logic [3:0]  field_index_reg,      field_index_next;
    logic [15:0] questions_left_reg,   questions_left_next;
    logic [15:0] answers_left_reg,     answers_left_next;
    logic [15:0] skip_count_reg,       skip_count_next;
    logic [15:0] record_type_reg,      record_type_next;
    logic [15:0] record_length_reg,    record_length_next;
    logic        server_error_reg,     server_error_next;
    logic        found_reg,            found_next;
    logic [31:0] captured_address_reg, captured_address_next;

    logic        out_valid_reg;
    status_t     status_reg,  status_next;
    logic [31:0] address_reg, address_next;

    logic [7:0]  b;
    logic [15:0] skip_dec;
    logic        accept;

    assign b        = msg.msg_byte;
    assign skip_dec = skip_count_reg - 16'd1;

    // A byte can be taken unless a finished result is still waiting
    assign msg.ready = !out_valid_reg || result.ready;
    assign accept    = msg.valid && msg.ready;

    // Parser next state for the incoming byte
    always_comb
    begin
        phase_next            = phase_reg;
        field_index_next      = field_index_reg;
        questions_left_next   = questions_left_reg;
        answers_left_next     = answers_left_reg;
        skip_count_next       = skip_count_reg;
        record_type_next      = record_type_reg;
        record_length_next    = record_length_reg;
        server_error_next     = server_error_reg;
        found_next            = found_reg;
        captured_address_next = captured_address_reg;

        case (phase_reg)
            PH_HEADER:
            begin
                if (field_index_reg == RCODE_IDX)
                    server_error_next = (b & RCODE_MASK) != 8'd0;
                else if (field_index_reg inside {QDCOUNT_HI, QDCOUNT_LO})
                    questions_left_next = {questions_left_reg[7:0], b};
                else if (field_index_reg inside {ANCOUNT_HI, ANCOUNT_LO})
                    answers_left_next = {answers_left_reg[7:0], b};
                if (field_index_reg >= HEADER_LAST)
                begin
                    field_index_next = 4'd0;
                    if (server_error_reg)
                        phase_next = PH_DONE;
                    else if (questions_left_reg != 16'd0 || answers_left_reg != 16'd0)
                        phase_next = PH_NAME_LEN;
                    else
                        phase_next = PH_DONE;
                end
                else
                begin
                    field_index_next = field_index_reg + 4'd1;
                end
            end

            PH_NAME_LEN:
            begin
                if (b == 8'd0)
                begin
                    // end of name
                    skip_count_next  = 16'd0;
                    field_index_next = 4'd0;
                    if (questions_left_reg != 16'd0)
                    begin
                        phase_next      = PH_QTAIL;
                        skip_count_next = QTAIL_LEN;
                    end
                    else
                    begin
                        phase_next         = PH_RR_FIXED;
                        record_type_next   = 16'd0;
                        record_length_next = 16'd0;
                    end
                end
                else if (b >= PTR_MARK)
                begin
                    // compression pointer: one more byte, then name ends
                    phase_next       = PH_NAME_SKIP;
                    skip_count_next  = 16'd1;
                    field_index_next = 4'd1;
                end
                else
                begin
                    phase_next       = PH_NAME_SKIP;
                    skip_count_next  = {8'd0, b};
                    field_index_next = 4'd0;
                end
            end

            PH_NAME_SKIP:
            begin
                skip_count_next = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    if (field_index_reg != 4'd0)
                    begin
                        // pointer finished the name
                        field_index_next = 4'd0;
                        if (questions_left_reg != 16'd0)
                        begin
                            phase_next      = PH_QTAIL;
                            skip_count_next = QTAIL_LEN;
                        end
                        else
                        begin
                            phase_next         = PH_RR_FIXED;
                            record_type_next   = 16'd0;
                            record_length_next = 16'd0;
                        end
                    end
                    else
                    begin
                        phase_next = PH_NAME_LEN;
                    end
                end
            end

            PH_QTAIL:
            begin
                skip_count_next = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    questions_left_next = questions_left_reg - 16'd1;
                    if (questions_left_next != 16'd0 || answers_left_reg != 16'd0)
                        phase_next = PH_NAME_LEN;
                    else
                        phase_next = PH_DONE;
                end
            end

            PH_RR_FIXED:
            begin
                if (field_index_reg <= TYPE_LO_IDX)
                    record_type_next = {record_type_reg[7:0], b};
                else if (field_index_reg inside {RDLEN_HI, RDLEN_LO})
                    record_length_next = {record_length_reg[7:0], b};
                if (field_index_reg >= RR_FIXED_LAST)
                begin
                    field_index_next = 4'd0;
                    if (record_type_next == TYPE_A && record_length_next == A_RDLEN)
                    begin
                        phase_next            = PH_CAPTURE;
                        captured_address_next = 32'd0;
                    end
                    else if (record_length_next == 16'd0)
                    begin
                        answers_left_next = answers_left_reg - 16'd1;
                        if (questions_left_reg != 16'd0 || answers_left_next != 16'd0)
                            phase_next = PH_NAME_LEN;
                        else
                            phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next      = PH_RR_SKIP;
                        skip_count_next = record_length_next;
                    end
                end
                else
                begin
                    field_index_next = field_index_reg + 4'd1;
                end
            end

            PH_CAPTURE:
            begin
                captured_address_next = {captured_address_reg[23:0], b};
                if (field_index_reg >= ADDR_LAST)
                begin
                    found_next       = 1'b1;
                    phase_next       = PH_DONE;
                    field_index_next = 4'd0;
                end
                else
                begin
                    field_index_next = field_index_reg + 4'd1;
                end
            end

            PH_RR_SKIP:
            begin
                skip_count_next = skip_dec;
                if (skip_dec == 16'd0)
                begin
                    answers_left_next = answers_left_reg - 16'd1;
                    if (questions_left_reg != 16'd0 || answers_left_next != 16'd0)
                        phase_next = PH_NAME_LEN;
                    else
                        phase_next = PH_DONE;
                end
            end

            default:
            begin
                // done: trailing bytes are ignored
            end
        endcase
    end

    // Result of the message, valid when the byte is final
    always_comb
    begin
        address_next = 32'd0;
        if (phase_next == PH_HEADER)
            status_next = ST_SHORT_HEADER;
        else if (server_error_next)
            status_next = ST_SERVER_ERROR;
        else if (found_next)
        begin
            status_next  = ST_FOUND;
            address_next = captured_address_next;
        end
        else
            status_next = ST_NO_RECORD;
    end

    // Parser state; a final byte returns it to the header phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg            <= PH_HEADER;
            field_index_reg      <= 4'd0;
            questions_left_reg   <= 16'd0;
            answers_left_reg     <= 16'd0;
            skip_count_reg       <= 16'd0;
            record_type_reg      <= 16'd0;
            record_length_reg    <= 16'd0;
            server_error_reg     <= 1'b0;
            found_reg            <= 1'b0;
            captured_address_reg <= 32'd0;
        end
        else if (accept)
        begin
            if (msg.final_byte)
            begin
                phase_reg            <= PH_HEADER;
                field_index_reg      <= 4'd0;
                questions_left_reg   <= 16'd0;
                answers_left_reg     <= 16'd0;
                skip_count_reg       <= 16'd0;
                record_type_reg      <= 16'd0;
                record_length_reg    <= 16'd0;
                server_error_reg     <= 1'b0;
                found_reg            <= 1'b0;
                captured_address_reg <= 32'd0;
            end
            else
            begin
                phase_reg            <= phase_next;
                field_index_reg      <= field_index_next;
                questions_left_reg   <= questions_left_next;
                answers_left_reg     <= answers_left_next;
                skip_count_reg       <= skip_count_next;
                record_type_reg      <= record_type_next;
                record_length_reg    <= record_length_next;
                server_error_reg     <= server_error_next;
                found_reg            <= found_next;
                captured_address_reg <= captured_address_next;
            end
        end
    end

    // Result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept && msg.final_byte)
            out_valid_reg <= 1'b1;
        else if (result.ready)
            out_valid_reg <= 1'b0;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (accept && msg.final_byte)
        begin
            status_reg  <= status_next;
            address_reg <= address_next;
        end
    end

    assign result.valid   = out_valid_reg;
    assign result.status  = status_reg;
    assign result.address = address_reg;

endmodule
